// ===== hdl/vdm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vdm_pkg;

    localparam int COORD_W     = 64;
    localparam int IDX_W       = 10;
    localparam int VEC_W       = 3 * COORD_W;
    localparam int IN_TDATA_W  = 216;
    localparam int OUT_TDATA_W = 24;

    typedef logic [1:0]       kind_t;
    typedef logic [1:0]       status_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam kind_t KIND_BEGIN = 2'd0;
    localparam kind_t KIND_POS   = 2'd1;
    localparam kind_t KIND_NRM   = 2'd2;
    localparam kind_t KIND_FACE  = 2'd3;

    localparam status_t STAT_OK   = 2'd0;
    localparam status_t STAT_FULL = 2'd1;
    localparam status_t STAT_REF  = 2'd2;

    // result word, lowest bits first: status, index_out, normal_index_out, was_new
    function automatic logic [OUT_TDATA_W-1:0] pack_result(
        input status_t st,
        input idx_t    idx,
        input idx_t    nidx,
        input logic    fresh
    );
        pack_result = {1'b0, fresh, nidx, idx, st};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vdm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vdm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/vertex_dedup_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Mesh vertex merge with dedup. Each input transfer is one command chosen by
// s_tuser (0 begin mesh, 1 position, 2 normal, 3 face corner) and gives
// exactly one result transfer. A position or normal is looked up by a linear
// sweep of its vector store, one stored entry per cycle through the store's
// single read port, so it holds the block for the whole sweep; a hit reuses
// the first matching index and a miss appends. A face corner makes two reads
// of the shared remap memory. Input is taken only while the block is idle; a
// finished result waits in the output register while the next command is
// accepted. Stores are not cleared at reset: only entries below the fill and
// incoming counters are ever read.

module vertex_dedup_merge #(
    parameter int STORE_DEPTH = 1024,
    parameter int REMAP_DEPTH = 1024
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // coord_x, coord_y, coord_z, vertex_ref, normal_ref (low bits first)
    input  wire logic [vdm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // kind
    input  wire logic [1:0]                         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // status, index_out, normal_index_out, was_new (low bits first)
    output logic      [vdm_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int SA = $clog2(STORE_DEPTH);
    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam int RA = $clog2(REMAP_DEPTH);
    localparam int RW = $clog2(REMAP_DEPTH + 1);
    localparam int VW = vdm_pkg::VEC_W;
    localparam int IW = vdm_pkg::IDX_W;
    localparam int OW = vdm_pkg::OUT_TDATA_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_FACE_P = 3'd2;
    localparam logic [2:0] ST_FACE_N = 3'd3;
    localparam logic [2:0] ST_FACE_W = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic          sel_reg, sel_next;
    logic [VW-1:0] vec_reg, vec_next;
    logic [IW-1:0] vref_reg, vref_next;
    logic [IW-1:0] nref_reg, nref_next;
    logic [FW-1:0] scan_reg, scan_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [FW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [FW-1:0] pos_fill_reg, pos_fill_next;
    logic [FW-1:0] nrm_fill_reg, nrm_fill_next;
    logic [RW-1:0] pos_inc_reg, pos_inc_next;
    logic [RW-1:0] nrm_inc_reg, nrm_inc_next;
    logic [OW-1:0] res_reg, res_next;
    logic [SA-1:0] pidx_reg, pidx_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [OW-1:0] m_tdata_reg, m_tdata_next;

    // vector store: entries of both kinds, kind select is the address msb
    logic          vs_wr_en;
    logic [SA:0]   vs_wr_addr;
    logic          vs_rd_en;
    logic [SA:0]   vs_rd_addr;
    logic [VW-1:0] vs_rd_data;

    // remap tables, same layout
    logic          rm_wr_en;
    logic [RA:0]   rm_wr_addr;
    logic [SA-1:0] rm_wr_data;
    logic          rm_rd_en;
    logic [RA:0]   rm_rd_addr;
    logic [SA-1:0] rm_rd_data;

    vdm_ram #(
        .WIDTH (VW),
        .DEPTH (2 << SA)
    ) u_vec_store (
        .aclk    (aclk),
        .wr_en   (vs_wr_en),
        .wr_addr (vs_wr_addr),
        .wr_data (vec_reg),
        .rd_en   (vs_rd_en),
        .rd_addr (vs_rd_addr),
        .rd_data (vs_rd_data)
    );

    vdm_ram #(
        .WIDTH (SA),
        .DEPTH (2 << RA)
    ) u_remap (
        .aclk    (aclk),
        .wr_en   (rm_wr_en),
        .wr_addr (rm_wr_addr),
        .wr_data (rm_wr_data),
        .rd_en   (rm_rd_en),
        .rd_addr (rm_rd_addr),
        .rd_data (rm_rd_data)
    );

    vdm_pkg::kind_t kind_in;
    logic [IW-1:0]  vref_in;
    logic [IW-1:0]  nref_in;
    logic [RW-1:0]  in_inc;
    logic           ref_bad;
    logic [FW-1:0]  fill_sel;
    logic [RW-1:0]  inc_sel;
    logic           vec_match;
    logic           scan_end;
    logic           scan_issue;
    logic           store_full;

    assign kind_in  = s_tuser;
    assign vref_in  = s_tdata[VW +: IW];
    assign nref_in  = s_tdata[VW + IW +: IW];
    assign in_inc   = (kind_in == vdm_pkg::KIND_NRM) ? nrm_inc_reg : pos_inc_reg;
    assign ref_bad  = (32'(vref_in) >= 32'(pos_inc_reg)) ||
                      (32'(nref_in) >= 32'(nrm_inc_reg));

    assign fill_sel   = sel_reg ? nrm_fill_reg : pos_fill_reg;
    assign inc_sel    = sel_reg ? nrm_inc_reg : pos_inc_reg;
    assign vec_match  = cmp_vld_reg && (vs_rd_data == vec_reg);
    // last compare done, or nothing stored at all
    assign scan_end   = cmp_vld_reg ? (FW'(cmp_idx_reg + 1'b1) == fill_sel)
                                    : (scan_reg == fill_sel);
    assign scan_issue = (state_reg == ST_SCAN) && (scan_reg < fill_sel);
    assign store_full = (fill_sel == FW'(STORE_DEPTH));

    assign vs_rd_en   = scan_issue;
    assign vs_rd_addr = {sel_reg, scan_reg[SA-1:0]};
    assign vs_wr_addr = {sel_reg, fill_sel[SA-1:0]};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        logic          do_rec;
        logic [SA-1:0] rec_idx;
        logic          rec_fresh;

        state_next    = state_reg;
        sel_next      = sel_reg;
        vec_next      = vec_reg;
        vref_next     = vref_reg;
        nref_next     = nref_reg;
        scan_next     = scan_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        pos_fill_next = pos_fill_reg;
        nrm_fill_next = nrm_fill_reg;
        pos_inc_next  = pos_inc_reg;
        nrm_inc_next  = nrm_inc_reg;
        res_next      = res_reg;
        pidx_next     = pidx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        vs_wr_en   = 1'b0;
        rm_wr_en   = 1'b0;
        rm_wr_addr = {sel_reg, inc_sel[RA-1:0]};
        rm_rd_en   = 1'b0;
        rm_rd_addr = {1'b0, RA'(32'(vref_reg))};
        do_rec     = 1'b0;
        rec_idx    = cmp_idx_reg[SA-1:0];
        rec_fresh  = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    vec_next  = s_tdata[VW-1:0];
                    vref_next = vref_in;
                    nref_next = nref_in;
                    sel_next  = (kind_in == vdm_pkg::KIND_NRM);
                    unique case (kind_in)
                        vdm_pkg::KIND_BEGIN: begin
                            pos_inc_next = '0;
                            nrm_inc_next = '0;
                            res_next     = vdm_pkg::pack_result(vdm_pkg::STAT_OK,
                                                                '0, '0, 1'b0);
                            state_next   = ST_OUT;
                        end
                        vdm_pkg::KIND_POS, vdm_pkg::KIND_NRM: begin
                            if (in_inc == RW'(REMAP_DEPTH)) begin
                                res_next   = vdm_pkg::pack_result(vdm_pkg::STAT_FULL,
                                                                  '0, '0, 1'b0);
                                state_next = ST_OUT;
                            end else begin
                                scan_next    = '0;
                                cmp_vld_next = 1'b0;
                                state_next   = ST_SCAN;
                            end
                        end
                        vdm_pkg::KIND_FACE: begin
                            if (ref_bad) begin
                                res_next   = vdm_pkg::pack_result(vdm_pkg::STAT_REF,
                                                                  '0, '0, 1'b0);
                                state_next = ST_OUT;
                            end else begin
                                state_next = ST_FACE_P;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // read of entry n is in flight while entry n-1 is compared
                priority if (vec_match) begin
                    do_rec     = 1'b1;
                    state_next = ST_OUT;
                end else if (scan_end) begin
                    if (store_full) begin
                        res_next = vdm_pkg::pack_result(vdm_pkg::STAT_FULL,
                                                        '0, '0, 1'b0);
                    end else begin
                        vs_wr_en  = 1'b1;
                        do_rec    = 1'b1;
                        rec_idx   = fill_sel[SA-1:0];
                        rec_fresh = 1'b1;
                        if (sel_reg) begin
                            nrm_fill_next = nrm_fill_reg + 1'b1;
                        end else begin
                            pos_fill_next = pos_fill_reg + 1'b1;
                        end
                    end
                    state_next = ST_OUT;
                end else begin
                    if (scan_issue) begin
                        scan_next = scan_reg + 1'b1;
                    end
                    cmp_vld_next = scan_issue;
                    cmp_idx_next = scan_reg;
                end
            end
            ST_FACE_P: begin
                rm_rd_en   = 1'b1;
                rm_rd_addr = {1'b0, RA'(32'(vref_reg))};
                state_next = ST_FACE_N;
            end
            ST_FACE_N: begin
                pidx_next  = rm_rd_data;
                rm_rd_en   = 1'b1;
                rm_rd_addr = {1'b1, RA'(32'(nref_reg))};
                state_next = ST_FACE_W;
            end
            ST_FACE_W: begin
                res_next   = vdm_pkg::pack_result(vdm_pkg::STAT_OK,
                                                  IW'(32'(pidx_reg)),
                                                  IW'(32'(rm_rd_data)), 1'b0);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        rm_wr_data = rec_idx;
        if (do_rec) begin
            rm_wr_en = 1'b1;
            res_next = vdm_pkg::pack_result(vdm_pkg::STAT_OK, IW'(32'(rec_idx)),
                                            '0, rec_fresh);
            if (sel_reg) begin
                nrm_inc_next = nrm_inc_reg + 1'b1;
            end else begin
                pos_inc_next = pos_inc_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cmp_vld_reg  <= 1'b0;
            pos_fill_reg <= '0;
            nrm_fill_reg <= '0;
            pos_inc_reg  <= '0;
            nrm_inc_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cmp_vld_reg  <= cmp_vld_next;
            pos_fill_reg <= pos_fill_next;
            nrm_fill_reg <= nrm_fill_next;
            pos_inc_reg  <= pos_inc_next;
            nrm_inc_reg  <= nrm_inc_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg     <= sel_next;
        vec_reg     <= vec_next;
        vref_reg    <= vref_next;
        nref_reg    <= nref_next;
        scan_reg    <= scan_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
        pidx_reg    <= pidx_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// ===== tb/sv/vertex_dedup_merge_tb.sv =====
`timescale 1ns / 1ps

module vertex_dedup_merge_tb;

    localparam int CLK_PERIOD   = 4;
    localparam int STORE_DEPTH  = 1024;
    localparam int REMAP_DEPTH  = 1024;
    // worst search holds the block for a sweep of the whole store, plus output stalls
    localparam int STALL_LIMIT  = 10000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        vdm_pkg::status_t status;
        vdm_pkg::idx_t    index;
        vdm_pkg::idx_t    nindex;
        logic             fresh;
    } merge_result_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // coord_x, coord_y, coord_z, vertex_ref, normal_ref (low bits first)
    logic [vdm_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    // kind
    logic [1:0]                      s_tuser  = vdm_pkg::KIND_BEGIN;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // status, index_out, normal_index_out, was_new (low bits first)
    logic [vdm_pkg::OUT_TDATA_W-1:0] m_tdata;

    // shadow copy of the merged stores and the per-mesh remap tables
    logic [63:0]   store_x  [vdm_pkg::KIND_POS:vdm_pkg::KIND_NRM][STORE_DEPTH];
    logic [63:0]   store_y  [vdm_pkg::KIND_POS:vdm_pkg::KIND_NRM][STORE_DEPTH];
    logic [63:0]   store_z  [vdm_pkg::KIND_POS:vdm_pkg::KIND_NRM][STORE_DEPTH];
    vdm_pkg::idx_t remap    [vdm_pkg::KIND_POS:vdm_pkg::KIND_NRM][REMAP_DEPTH];
    int            fill     [vdm_pkg::KIND_POS:vdm_pkg::KIND_NRM] = '{default: 0};
    int            incoming [vdm_pkg::KIND_POS:vdm_pkg::KIND_NRM] = '{default: 0};

    merge_result_t expected_q[$];

    int errors          = 0;
    int results_checked = 0;
    int full_results    = 0;
    int bad_ref_results = 0;
    int kind_totals [vdm_pkg::KIND_BEGIN:vdm_pkg::KIND_FACE] = '{default: 0};
    int burst_left      = 0;
    int idle_cycles     = 0;

    int unsigned stall_left = 0;
    int unsigned stall_mode = 0;
    int unsigned rx_cycle   = 0;

    vertex_dedup_merge #(
        .STORE_DEPTH (STORE_DEPTH),
        .REMAP_DEPTH (REMAP_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Applies one command to the shadow state and returns the result it gives.
    function automatic merge_result_t predict_merge(input vdm_pkg::kind_t k,
                                                    input logic [63:0] x,
                                                    input logic [63:0] y,
                                                    input logic [63:0] z,
                                                    input vdm_pkg::idx_t vr,
                                                    input vdm_pkg::idx_t nr);
        merge_result_t r;
        logic          found;
        int            hit;
        r     = '0;
        found = 1'b0;
        hit   = 0;
        case (k)
            vdm_pkg::KIND_BEGIN: begin
                incoming[vdm_pkg::KIND_POS] = 0;
                incoming[vdm_pkg::KIND_NRM] = 0;
            end
            vdm_pkg::KIND_POS, vdm_pkg::KIND_NRM: begin
                if (incoming[k] >= REMAP_DEPTH) begin
                    r.status = vdm_pkg::STAT_FULL;
                end else begin
                    for (int i = 0; i < fill[k]; i++) begin
                        if (!found && store_x[k][i] == x && store_y[k][i] == y &&
                            store_z[k][i] == z) begin
                            found = 1'b1;
                            hit   = i;
                        end
                    end
                    if (!found && fill[k] >= STORE_DEPTH) begin
                        r.status = vdm_pkg::STAT_FULL;
                    end else begin
                        if (!found) begin
                            hit = fill[k];
                            store_x[k][hit] = x;
                            store_y[k][hit] = y;
                            store_z[k][hit] = z;
                            fill[k]++;
                            r.fresh = 1'b1;
                        end
                        remap[k][incoming[k]] = vdm_pkg::idx_t'(hit);
                        incoming[k]++;
                        r.index = vdm_pkg::idx_t'(hit);
                    end
                end
            end
            default: begin
                if (vr >= incoming[vdm_pkg::KIND_POS] ||
                    nr >= incoming[vdm_pkg::KIND_NRM]) begin
                    r.status = vdm_pkg::STAT_REF;
                end else begin
                    r.index  = remap[vdm_pkg::KIND_POS][vr];
                    r.nindex = remap[vdm_pkg::KIND_NRM][nr];
                end
            end
        endcase
        return r;
    endfunction

    // One input transfer; the sender runs in bursts with random gaps between them.
    task automatic send_item(input vdm_pkg::kind_t k, input logic [63:0] x,
                             input logic [63:0] y, input logic [63:0] z,
                             input vdm_pkg::idx_t vr, input vdm_pkg::idx_t nr);
        merge_result_t want;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= {4'b0, nr, vr, z, y, x};
        do @(posedge aclk); while (!s_tready);
        want = predict_merge(k, x, y, z, vr, nr);
        expected_q.push_back(want);
        kind_totals[k]++;
        if (want.status == vdm_pkg::STAT_FULL) full_results++;
        if (want.status == vdm_pkg::STAT_REF) bad_ref_results++;
    endtask

    task automatic send_begin();
        send_item(vdm_pkg::KIND_BEGIN, rand64(), rand64(), rand64(),
                  vdm_pkg::idx_t'($urandom), vdm_pkg::idx_t'($urandom));
    endtask

    // Position or normal: mostly hits and near misses of stored vectors, else fresh.
    task automatic send_vector(input vdm_pkg::kind_t k);
        int          sel;
        int          pick;
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] z;
        sel = $urandom_range(0, 9);
        x   = rand64();
        y   = rand64();
        z   = rand64();
        if (fill[k] > 0 && sel < 6) begin
            pick = $urandom_range(0, fill[k] - 1);
            x = store_x[k][pick];
            y = store_y[k][pick];
            z = store_z[k][pick];
            // near miss: one bit off in one coordinate
            if (sel == 5) begin
                case ($urandom_range(0, 2))
                    0:       x[$urandom_range(0, 63)] ^= 1'b1;
                    1:       y[$urandom_range(0, 63)] ^= 1'b1;
                    default: z[$urandom_range(0, 63)] ^= 1'b1;
                endcase
            end
        end
        send_item(k, x, y, z, vdm_pkg::idx_t'($urandom), vdm_pkg::idx_t'($urandom));
    endtask

    // Face corner, mostly with refs inside the current mesh.
    task automatic send_face();
        int            sel;
        vdm_pkg::idx_t vr;
        vdm_pkg::idx_t nr;
        sel = $urandom_range(0, 19);
        vr  = (incoming[vdm_pkg::KIND_POS] > 0) ?
              vdm_pkg::idx_t'($urandom_range(0, incoming[vdm_pkg::KIND_POS] - 1)) : '0;
        nr  = (incoming[vdm_pkg::KIND_NRM] > 0) ?
              vdm_pkg::idx_t'($urandom_range(0, incoming[vdm_pkg::KIND_NRM] - 1)) : '0;
        if (sel == 0)      vr = vdm_pkg::idx_t'(incoming[vdm_pkg::KIND_POS]);
        else if (sel == 1) nr = vdm_pkg::idx_t'(incoming[vdm_pkg::KIND_NRM]);
        else if (sel == 2) vr = vdm_pkg::idx_t'($urandom);
        else if (sel == 3) nr = vdm_pkg::idx_t'($urandom);
        send_item(vdm_pkg::KIND_FACE, rand64(), rand64(), rand64(), vr, nr);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] MISMATCH result %0d: %s got 0x%0h expected 0x%0h",
                 $time, results_checked, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin : receiver_pattern
        rx_cycle <= rx_cycle + 1;
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (rx_cycle % 5 != 0);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin : result_check
        merge_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_checked++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected transfer", int'(m_tdata), 0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[1:0] != want.status)
                    report_mismatch("status", int'(m_tdata[1:0]), int'(want.status));
                if (m_tdata[11:2] != want.index)
                    report_mismatch("index_out", int'(m_tdata[11:2]), int'(want.index));
                if (m_tdata[21:12] != want.nindex)
                    report_mismatch("normal_index_out", int'(m_tdata[21:12]),
                                    int'(want.nindex));
                if (m_tdata[22] != want.fresh)
                    report_mismatch("was_new", int'(m_tdata[22]), int'(want.fresh));
                if (m_tdata[23] != 1'b0)
                    report_mismatch("pad bit", int'(m_tdata[23]), 0);
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] timeout: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, expected_q.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Hand-picked hits, misses and face lookups, incl. signed zero and NaN patterns.
    task automatic test_directed_dedup();
        send_item(vdm_pkg::KIND_BEGIN, '1, '1, '1, '1, '1);
        send_item(vdm_pkg::KIND_POS, '0, '0, '0, '0, '0);
        send_item(vdm_pkg::KIND_POS, '1, '1, '1, '0, '0);
        send_item(vdm_pkg::KIND_POS, '0, '0, '0, '1, '1);
        send_item(vdm_pkg::KIND_POS, 64'h8000_0000_0000_0000, '0, '0, '0, '0);
        send_item(vdm_pkg::KIND_POS, '0, '0, 64'h1, '0, '0);
        send_item(vdm_pkg::KIND_POS, '0, 64'h7FF8_0000_0000_0000, '0, '0, '0);
        send_item(vdm_pkg::KIND_POS, '0, 64'h7FF8_0000_0000_0000, '0, '0, '0);
        send_item(vdm_pkg::KIND_NRM, '1, '1, '1, '0, '0);
        send_item(vdm_pkg::KIND_NRM, 64'h3FF0_0000_0000_0000, '0, '0, '0, '0);
        send_item(vdm_pkg::KIND_NRM, '1, '1, '1, '0, '0);
        send_item(vdm_pkg::KIND_FACE, '0, '0, '0, vdm_pkg::idx_t'(4), vdm_pkg::idx_t'(2));
        send_item(vdm_pkg::KIND_FACE, '1, '1, '1, '0, '0);
        send_item(vdm_pkg::KIND_FACE, '0, '0, '0, vdm_pkg::idx_t'(7), '0);
        send_item(vdm_pkg::KIND_FACE, '0, '0, '0, '0, vdm_pkg::idx_t'(3));
        send_item(vdm_pkg::KIND_FACE, '0, '0, '0, '1, '1);
        send_item(vdm_pkg::KIND_BEGIN, '0, '0, '0, '0, '0);
        send_item(vdm_pkg::KIND_FACE, '0, '0, '0, '0, '0);
        send_item(vdm_pkg::KIND_NRM, 64'h3FF0_0000_0000_0000, '0, '0, '0, '0);
        send_item(vdm_pkg::KIND_POS, '1, '1, '1, '0, '0);
        send_item(vdm_pkg::KIND_FACE, '0, '0, '0, '0, '0);
        send_item(vdm_pkg::KIND_BEGIN, '0, '0, '0, '0, '0);
    endtask

    // Fill one remap table with hits, then overflow it with a hit and a miss.
    task automatic test_remap_full(input vdm_pkg::kind_t k);
        send_begin();
        while (incoming[k] < REMAP_DEPTH)
            send_item(k, store_x[k][0], store_y[k][0], store_z[k][0], '0, '0);
        send_item(k, store_x[k][0], store_y[k][0], store_z[k][0], '0, '0);
        send_item(k, rand64(), rand64(), rand64(), '0, '0);
        send_vector((k == vdm_pkg::KIND_POS) ? vdm_pkg::KIND_NRM : vdm_pkg::KIND_POS);
        send_item(vdm_pkg::KIND_FACE, '0, '0, '0,
                  vdm_pkg::idx_t'(incoming[vdm_pkg::KIND_POS] - 1),
                  vdm_pkg::idx_t'(incoming[vdm_pkg::KIND_NRM] - 1));
        repeat (4) send_face();
    endtask

    // Random meshes: mostly begin / positions / normals / faces, some loose noise.
    task automatic test_random_meshes(input int n_items);
        int done;
        int n_pos;
        int n_nrm;
        int n_face;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                n_pos  = $urandom_range(1, 10);
                n_nrm  = $urandom_range(1, 6);
                n_face = $urandom_range(1, 12);
                send_begin();
                repeat (n_pos) send_vector(vdm_pkg::KIND_POS);
                repeat (n_nrm) send_vector(vdm_pkg::KIND_NRM);
                repeat (n_face) send_face();
                done += 1 + n_pos + n_nrm + n_face;
            end else begin
                case ($urandom_range(0, 3))
                    0:       send_begin();
                    1:       send_vector(vdm_pkg::KIND_POS);
                    2:       send_vector(vdm_pkg::KIND_NRM);
                    default: send_item(vdm_pkg::KIND_FACE, rand64(), rand64(), rand64(),
                                       vdm_pkg::idx_t'($urandom),
                                       vdm_pkg::idx_t'($urandom));
                endcase
                done++;
            end
        end
    endtask

    // Append fresh vectors until the store is full, then miss and hit against it.
    task automatic test_store_full(input vdm_pkg::kind_t k);
        vdm_pkg::kind_t other;
        other = (k == vdm_pkg::KIND_POS) ? vdm_pkg::KIND_NRM : vdm_pkg::KIND_POS;
        send_begin();
        while (fill[k] < STORE_DEPTH) begin
            if (incoming[k] >= REMAP_DEPTH) send_begin();
            send_item(k, rand64(), rand64(), rand64(), '0, '0);
        end
        send_item(k, rand64(), rand64(), rand64(), '0, '0);
        send_item(k, store_x[k][STORE_DEPTH-1], store_y[k][STORE_DEPTH-1],
                  store_z[k][STORE_DEPTH-1], '0, '0);
        send_item(other, store_x[other][0], store_y[other][0], store_z[other][0], '0, '0);
        send_item(vdm_pkg::KIND_FACE, '0, '0, '0,
                  vdm_pkg::idx_t'(incoming[vdm_pkg::KIND_POS] - 1),
                  vdm_pkg::idx_t'(incoming[vdm_pkg::KIND_NRM] - 1));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_dedup();
        test_remap_full(vdm_pkg::KIND_POS);
        test_remap_full(vdm_pkg::KIND_NRM);
        test_random_meshes(580);
        test_store_full(vdm_pkg::KIND_POS);
        test_store_full(vdm_pkg::KIND_NRM);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d begin, %0d position, %0d normal, %0d face commands",
                 kind_totals[vdm_pkg::KIND_BEGIN], kind_totals[vdm_pkg::KIND_POS],
                 kind_totals[vdm_pkg::KIND_NRM], kind_totals[vdm_pkg::KIND_FACE]);
        $display("%0d results checked; stores ended at %0d positions / %0d normals; %0d full, %0d bad-reference results",
                 results_checked, fill[vdm_pkg::KIND_POS], fill[vdm_pkg::KIND_NRM],
                 full_results, bad_ref_results);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
